/* rtl/core/erpm_telemetry_gcr_encoder_defines.svh */
// assertion macros for the erpm telemetry gcr encoder
// used by rtl/core modules that carry concurrent checks; no other dependencies
`ifndef ERPM_TELEMETRY_GCR_ENCODER_DEFINES_SVH
`define ERPM_TELEMETRY_GCR_ENCODER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, disabled while reset is asserted
`define ERPM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("erpm telemetry check failed");
// next-cycle implication, disabled while reset is asserted
`define ERPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("erpm telemetry check failed");
`else
`define ERPM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ERPM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/erpm_tlm_pkg.sv */
// shared types, constants and the 4b/5b table for the erpm telemetry encoder
// no dependencies
`timescale 1ns / 1ps

package erpm_tlm_pkg;

    localparam int PERIOD_W  = 16;
    localparam int MANT_BITS = 9;
    localparam int EXP_W     = 3;
    localparam int FRAME_W   = 16;
    localparam int GCR_W     = 20;
    localparam int LINE_W    = 21;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX = 16'hFFFF;
    localparam logic [3:0]          NIBBLE_MASK = 4'hF;

    typedef struct packed {
        logic [15:0] comm_interval;
        logic        motor_running;
    } req_t;

    typedef struct packed {
        logic [15:0] telemetry_frame;
        logic [19:0] gcr_word;
        logic [20:0] line_pattern;
    } result_t;

    // standard telemetry 4b/5b code
    function automatic logic [4:0] gcr_5b(input logic [3:0] nib);
        logic [4:0] code;
        unique case (nib)
            4'h0: code = 5'h19;
            4'h1: code = 5'h1B;
            4'h2: code = 5'h12;
            4'h3: code = 5'h13;
            4'h4: code = 5'h1D;
            4'h5: code = 5'h15;
            4'h6: code = 5'h16;
            4'h7: code = 5'h17;
            4'h8: code = 5'h1A;
            4'h9: code = 5'h09;
            4'hA: code = 5'h0A;
            4'hB: code = 5'h0B;
            4'hC: code = 5'h1E;
            4'hD: code = 5'h0D;
            4'hE: code = 5'h0E;
            default: code = 5'h0F;
        endcase
        return code;
    endfunction

endpackage

/* rtl/core/erpm_telemetry_gcr_encoder.sv */
// top level of the erpm telemetry gcr encoder
// depends on erpm_tlm_pkg, erpm_tlm_frame, erpm_tlm_gcr and the assertion macro header
`timescale 1ns / 1ps
`include "erpm_telemetry_gcr_encoder_defines.svh"

// usage
//   input channel: drive request with start high; the item is taken at the clock
//   edge where start is high and busy is low. busy is always low, so an item can
//   be offered in every cycle.
//   result channel: done is high for exactly one cycle with result holding the
//   telemetry frame, its 20-bit gcr word and the 21-level line pattern.
//   path: an accepted item passes the input register, then the result register;
//   done rises with the result as the result register loads.
//   throughput: 1 item per cycle; the encode is a short path of an add,
//   a saturate, a 7-way priority pick, a shift and table lookups.
//   reset: rst_n low clears the valid flags at once, so no done pulse comes
//   out for items that were in flight; payload registers are not reset.
//   stall: the receiver cannot hold results off, and none is needed since
//   every result is shown for exactly one cycle and replaced by the next.

module erpm_telemetry_gcr_encoder
    import erpm_tlm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  req_t    request,
    output logic    done,
    output result_t result
);

    // input stage
    logic    valid_reg;
    logic    valid_next;
    req_t    req_reg;

    // result stage
    logic    done_reg;
    logic    done_next;
    result_t result_reg;
    result_t result_next;

    logic [15:0] frame;
    logic [19:0] gcr_word;
    logic [20:0] line_pattern;

    // never stalls: one item per cycle
    assign busy       = 1'b0;
    assign valid_next = start && !busy;
    assign done_next  = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    // payload registers, loaded only when a new item moves in
    always_ff @(posedge clk)
    begin
        if (valid_next)
        begin
            req_reg <= request;
        end
        if (done_next)
        begin
            result_reg <= result_next;
        end
    end

    // period, packing and checksum
    erpm_tlm_frame u_frame (
        .req   (req_reg),
        .frame (frame)
    );

    // gcr code and line levels
    erpm_tlm_gcr u_gcr (
        .frame        (frame),
        .gcr_word     (gcr_word),
        .line_pattern (line_pattern)
    );

    always_comb
    begin
        result_next.telemetry_frame = frame;
        result_next.gcr_word        = gcr_word;
        result_next.line_pattern    = line_pattern;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // an accepted item shows up as a done pulse, and nothing else does
    `ERPM_ASSERT_IMPL(a_accept_gives_done, clk, rst_n, start && !busy, ##2 done)
    `ERPM_ASSERT_IMPL(a_no_spurious_done, clk, rst_n, !start, ##2 !done)
    // delivered frame carries a consistent checksum
    `ERPM_ASSERT_IMPL(a_checksum_ok, clk, rst_n, done, (~(result.telemetry_frame[15:12] ^ result.telemetry_frame[11:8] ^ result.telemetry_frame[7:4]) == result.telemetry_frame[3:0]))
    // line pattern always opens high
    `ERPM_ASSERT_IMPL(a_line_starts_high, clk, rst_n, done, result.line_pattern[20])
    // stopped motor yields the maximum period code
    `ERPM_ASSERT_NEXT(a_stopped_max, clk, rst_n, valid_reg && !req_reg.motor_running, result.telemetry_frame[15:4] == 12'hFFF)

endmodule

/* rtl/core/erpm_tlm_frame.sv */
// period forming, exponent/mantissa packing and checksum
// depends on erpm_tlm_pkg
`timescale 1ns / 1ps

module erpm_tlm_frame
    import erpm_tlm_pkg::*;
(
    input  req_t        req,
    output logic [15:0] frame
);

    logic [17:0]          prod;
    logic [PERIOD_W-1:0]  period;
    logic [EXP_W-1:0]     expo;
    logic [MANT_BITS-1:0] mant;
    logic [11:0]          packed12;
    logic [3:0]           csum;

    // interval * 3 as shift and add
    assign prod   = {2'b00, req.comm_interval} + {1'b0, req.comm_interval, 1'b0};
    assign period = (!req.motor_running || (prod[17:16] != 2'b00)) ?
                    PERIOD_MAX : prod[15:0];

    // highest set bit among 15..9 picks the shift
    always_comb
    begin
        expo = '0;
        for (int h = MANT_BITS; h < PERIOD_W; h++)
        begin
            if (period[h])
            begin
                expo = EXP_W'(h - (MANT_BITS - 1));
            end
        end
    end

    assign mant     = MANT_BITS'(period >> expo);
    assign packed12 = {expo, mant};
    assign csum     = ~(packed12[11:8] ^ packed12[7:4] ^ packed12[3:0]) & NIBBLE_MASK;
    assign frame    = {packed12, csum};

endmodule

/* rtl/core/erpm_tlm_gcr.sv */
// 4b/5b gcr encoding of the frame and conversion to line levels
// depends on erpm_tlm_pkg
`timescale 1ns / 1ps

module erpm_tlm_gcr
    import erpm_tlm_pkg::*;
(
    input  logic [15:0] frame,
    output logic [19:0] gcr_word,
    output logic [20:0] line_pattern
);

    assign gcr_word = {gcr_5b(frame[15:12]), gcr_5b(frame[11:8]),
                       gcr_5b(frame[7:4]),   gcr_5b(frame[3:0])};

    // each level is one xor-ed with the parity of its own gcr bit and all gcr bits above it
    always_comb
    begin
        line_pattern[LINE_W-1] = 1'b1;
        for (int i = 0; i < GCR_W; i++)
        begin
            line_pattern[i] = ~(^(gcr_word >> i));
        end
    end

endmodule

/* tb/sv/tb_erpm_telemetry_gcr_encoder.sv */
// self-checking testbench for erpm_telemetry_gcr_encoder: directed and random items
// depends on erpm_tlm_pkg for the request and result types; predicts every reply itself
`timescale 1ns / 1ps

module tb_erpm_telemetry_gcr_encoder;
    import erpm_tlm_pkg::*;

    // cycles with neither an accepted item nor a done pulse before the run is abandoned
    localparam int unsigned STALL_LIMIT = 3000;
    // the block answers after its input and result registers; drain a little longer
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned PHASE_ITEMS = 509;

    // telemetry 4b/5b code, indexed by the nibble
    localparam logic [4:0] NIBBLE_CODE [16] = '{
        5'h19, 5'h1B, 5'h12, 5'h13, 5'h1D, 5'h15, 5'h16, 5'h17,
        5'h1A, 5'h09, 5'h0A, 5'h0B, 5'h1E, 5'h0D, 5'h0E, 5'h0F
    };

    // directed intervals: zero and small values, both sides of every exponent step
    // (tripled interval crossing 512, 1024 ... 32768), exact 65535 and just past it,
    // the full-scale interval, and stopped-motor items with small and large intervals
    localparam int unsigned DIRECTED_COUNT = 24;
    localparam logic [15:0] DIRECTED_INTERVAL [DIRECTED_COUNT] = '{
        16'd0,     16'd1,     16'd2,     16'd170,   16'd171,   16'd341,
        16'd342,   16'd682,   16'd683,   16'd1365,  16'd1366,  16'd2730,
        16'd2731,  16'd5461,  16'd5462,  16'd10922, 16'd10923, 16'd21845,
        16'd21846, 16'd65535, 16'h8000,  16'd65535, 16'd0,     16'hAAAA
    };
    localparam logic DIRECTED_RUNNING [DIRECTED_COUNT] = '{
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0
    };

    // keeps the replies still owed by the block, oldest first
    class telemetry_scoreboard;
        result_t pending_replies[$];
        int unsigned error_count;

        function new();
            error_count = 0;
        endfunction

        // period, exponent/mantissa pack, checksum, gcr and line levels for one item
        function result_t expected_reply(req_t item);
            logic [17:0] tripled;
            logic [15:0] period;
            logic [2:0]  expo;
            logic [8:0]  mant;
            logic [11:0] packed_val;
            logic [3:0]  csum;
            logic [15:0] frame;
            logic [19:0] gcr;
            logic [20:0] levels;
            result_t     reply;
            int          h;
            tripled = 18'(item.comm_interval) * 18'd3;
            period = (tripled > 18'(PERIOD_MAX)) ? PERIOD_MAX : tripled[15:0];
            if (!item.motor_running)
                period = PERIOD_MAX;
            // highest set bit among 15..9 picks the shift
            expo = 3'd0;
            for (h = 9; h <= 15; h++)
                if (period[h])
                    expo = 3'(h - 8);
            mant = 9'(period >> expo);
            packed_val = {expo, mant};
            csum = ~(packed_val[11:8] ^ packed_val[7:4] ^ packed_val[3:0]);
            frame = {packed_val, csum};
            gcr = {NIBBLE_CODE[frame[15:12]], NIBBLE_CODE[frame[11:8]],
                   NIBBLE_CODE[frame[7:4]], NIBBLE_CODE[frame[3:0]]};
            // line starts high and toggles on every gcr one
            levels[20] = 1'b1;
            for (h = 19; h >= 0; h--)
                levels[h] = levels[h + 1] ^ gcr[h];
            reply.telemetry_frame = frame;
            reply.gcr_word = gcr;
            reply.line_pattern = levels;
            return reply;
        endfunction

        function void note_request(req_t item);
            pending_replies.push_back(expected_reply(item));
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
                error_count++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_replies.size() == 0) begin
                $error("result 0x%0h with no item outstanding", got);
                error_count++;
            end
            else begin
                want = pending_replies.pop_front();
                compare_field("telemetry_frame", want.telemetry_frame, got.telemetry_frame);
                compare_field("gcr_word", want.gcr_word, got.gcr_word);
                compare_field("line_pattern", want.line_pattern, got.line_pattern);
            end
        endfunction

        function int unsigned outstanding();
            return pending_replies.size();
        endfunction
    endclass

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    req_t    request = '0;
    logic    done;
    result_t result;

    telemetry_scoreboard sb = new();
    int unsigned quiet_cycles = 0;

    erpm_telemetry_gcr_encoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // monitor: values read at the edge are the ones the block saw
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (done)
                sb.check_result(result);
            if (start && !busy)
                sb.note_request(request);
        end
    end

    // watchdog: nothing moving on either side for too long ends the run
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_erpm_telemetry_gcr_encoder: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // offer one item and hold it until the block takes it; called at a rising edge
    task automatic send_item(input req_t item);
        start <= 1'b1;
        request <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // sender gap: each further idle cycle is taken with the given percentage
    task automatic idle_gap(input int unsigned pct);
        if ($urandom_range(99) < pct) begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < pct);
        end
    endtask

    // mix of full-range, non-saturating, small and near-boundary intervals;
    // about one item in eight has the motor stopped
    function automatic req_t draw_request();
        req_t item;
        case ($urandom_range(3))
            0: item.comm_interval = 16'($urandom_range(65535));
            1: item.comm_interval = 16'($urandom_range(21845));
            2: item.comm_interval = 16'($urandom_range(200));
            default: item.comm_interval =
                16'((32'd171 << $urandom_range(6)) + $urandom_range(4) - 2);
        endcase
        item.motor_running = ($urandom_range(7) != 0);
        return item;
    endfunction

    task automatic random_phase(input int unsigned count, input int unsigned idle_pct);
        repeat (count)
        begin
            send_item(draw_request());
            idle_gap(idle_pct);
        end
    endtask

    initial
    begin
        req_t item;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items back to back
        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            item.comm_interval = DIRECTED_INTERVAL[i];
            item.motor_running = DIRECTED_RUNNING[i];
            send_item(item);
        end

        // light sender gaps, then heavy gaps, then a steady stream
        random_phase(PHASE_ITEMS, 10);
        random_phase(PHASE_ITEMS, 81);
        random_phase(PHASE_ITEMS, 0);
        start <= 1'b0;

        // wait out the replies still in flight; the watchdog bounds this
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.error_count == 0)
            $display("tb_erpm_telemetry_gcr_encoder: clean");
        else
            $display("tb_erpm_telemetry_gcr_encoder: errors");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/erpm_tlm_pkg.sv
rtl/core/erpm_tlm_frame.sv
rtl/core/erpm_tlm_gcr.sv
rtl/core/erpm_telemetry_gcr_encoder.sv
tb/sv/tb_erpm_telemetry_gcr_encoder.sv
